// ===== sv/polyline_fixed_length_cutter_top_assert.svh =====
// assertion macros for the polyline cutter
`ifndef POLYLINE_FIXED_LENGTH_CUTTER_TOP_ASSERT_SVH
`define POLYLINE_FIXED_LENGTH_CUTTER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pfc_pkg.sv =====
// shared types and constants of the polyline cutter
package pfc_pkg;

	localparam int LEN_BITS = 40;
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
	localparam int SQRT_STEPS = 40;
	localparam int RAD_BITS = 80;

	typedef logic [1:0] alu_op_t;
	localparam alu_op_t OP_MUL = 2'd0;
	localparam alu_op_t OP_DIV = 2'd1;
	localparam alu_op_t OP_SQRT = 2'd2;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_START = 2'd0;
	localparam kind_t KIND_CUT = 2'd1;
	localparam kind_t KIND_VERTEX = 2'd2;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_DIST_MODE = 3'd0;
	localparam reg_idx_t REG_LENGTH_CAPS = 3'd1;
	localparam reg_idx_t REG_NUMBER_CAPS = 3'd2;
	localparam reg_idx_t REG_CUT_COUNT = 3'd3;
	localparam reg_idx_t REG_CUT_LENGTH = 3'd4;

	typedef struct packed {
		logic start;
		alu_op_t op;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

endpackage

// ===== sv/pfc_alu.sv =====
// shared serial unit: shift-add multiply, restoring divide, digit-by-digit square root
module pfc_alu #(
	parameter int COORD_BITS = 40,
	localparam int BW = (COORD_BITS > pfc_pkg::LEN_BITS) ? COORD_BITS : pfc_pkg::LEN_BITS,
	localparam int PW = COORD_BITS + BW
) (
	input logic clk,
	input logic arst_n,
	input pfc_pkg::alu_ctl_t ctl,
	input logic [COORD_BITS-1:0] opa,
	input logic [BW-1:0] opb,
	input logic [PW-1:0] opn,
	input logic [pfc_pkg::LEN_BITS-1:0] opd,
	input logic [pfc_pkg::RAD_BITS-1:0] rad,
	output pfc_pkg::alu_sts_t sts,
	output logic [PW-1:0] prod,
	output logic [BW-1:0] quot,
	output logic [pfc_pkg::LEN_BITS-1:0] rem,
	output logic [pfc_pkg::LEN_BITS-1:0] root
);

	localparam int SHW = (PW > pfc_pkg::RAD_BITS) ? PW : pfc_pkg::RAD_BITS;
	localparam int CW = $clog2(BW + 1);
	localparam int LB = pfc_pkg::LEN_BITS;
	localparam int RW = LB + 3;

	pfc_pkg::alu_op_t op_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [SHW-1:0] acc_q;
	logic [BW-1:0] b_q;
	logic [COORD_BITS-1:0] a_q;
	logic [RW-1:0] rem_q;
	logic [LB-1:0] root_q, d_q;

	logic [PW-1:0] mul_nx;
	logic [LB:0] dr2;
	logic dge;
	logic [RW+1:0] sr2, strial;
	logic sge;

	assign mul_nx = {acc_q[PW-2:0], 1'b0} + (b_q[BW-1] ? PW'(a_q) : '0);
	assign dr2 = {rem_q[LB-1:0], acc_q[BW-1]};
	assign dge = dr2 >= {1'b0, d_q};
	assign sr2 = {rem_q, acc_q[pfc_pkg::RAD_BITS-1 -: 2]};
	assign strial = {3'b000, root_q, 2'b01};
	assign sge = sr2 >= strial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= pfc_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q <= ctl.op;
				cnt_q <= (ctl.op == pfc_pkg::OP_SQRT) ? CW'(pfc_pkg::SQRT_STEPS) : CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			case (ctl.op)
				pfc_pkg::OP_MUL: begin
					acc_q <= '0;
					a_q <= opa;
					b_q <= opb;
				end
				pfc_pkg::OP_DIV: begin
					acc_q <= SHW'(opn[BW-1:0]);
					rem_q <= RW'(opn >> BW);
					d_q <= opd;
				end
				default: begin
					acc_q <= SHW'(rad);
					rem_q <= '0;
					root_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				pfc_pkg::OP_MUL: begin
					acc_q <= SHW'(mul_nx);
					b_q <= {b_q[BW-2:0], 1'b0};
				end
				pfc_pkg::OP_DIV: begin
					acc_q <= {acc_q[SHW-1:BW], acc_q[BW-2:0], dge};
					rem_q <= dge ? RW'(dr2 - {1'b0, d_q}) : RW'(dr2);
				end
				default: begin
					acc_q <= {acc_q[SHW-3:0], 2'b00};
					rem_q <= sge ? RW'(sr2 - strial) : RW'(sr2);
					root_q <= {root_q[LB-2:0], sge};
				end
			endcase
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod = acc_q[PW-1:0];
	assign quot = acc_q[BW-1:0];
	assign rem = rem_q[LB-1:0];
	assign root = root_q;

endmodule

// ===== sv/polyline_fixed_length_cutter_top.sv =====
// Polyline cutter: takes one vertex per word and emits the part start point, the
// interpolated cut points and the vertex, splitting each part into pieces by length or
// by count. All arithmetic runs through one serial unit (pfc_alu) that does one bit per
// cycle, so a vertex is accepted only after the previous one's vertex word is issued.
// Multiplies and divides work on BW = max(COORD_BITS, 40) bit operands. The segment length
// of a vertex takes two squares and the square root, and each cut point takes two
// products and two divisions. A part start word takes a division when its piece length
// needs one. Output stalls hold the work.
module polyline_fixed_length_cutter_top #(
	parameter int COORD_BITS = 40,
	parameter int MAX_CUTS = 62
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [COORD_BITS-1:0] vertex_x,
	input logic signed [COORD_BITS-1:0] vertex_y,
	input logic part_start,
	input logic [pfc_pkg::LEN_BITS-1:0] part_length,
	output logic out_valid,
	input logic out_ready,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic [1:0] point_kind,
	output logic overflow,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [pfc_pkg::LEN_BITS-1:0] cfg_data
);

	localparam int LB = pfc_pkg::LEN_BITS;
	localparam int BW = (COORD_BITS > LB) ? COORD_BITS : LB;
	localparam int PW = COORD_BITS + BW;
	localparam int SHW = (PW > pfc_pkg::RAD_BITS) ? PW : pfc_pkg::RAD_BITS;
	localparam int SUMW = SHW + 1;
	localparam int CTW = $clog2(MAX_CUTS + 1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_PART = 5'd1;
	localparam logic [4:0] S_PREP = 5'd2;
	localparam logic [4:0] S_START = 5'd3;
	localparam logic [4:0] S_SQX = 5'd4;
	localparam logic [4:0] S_SQY = 5'd5;
	localparam logic [4:0] S_SQRT = 5'd6;
	localparam logic [4:0] S_SEG = 5'd7;
	localparam logic [4:0] S_LOOP = 5'd8;
	localparam logic [4:0] S_OVF = 5'd9;
	localparam logic [4:0] S_MX = 5'd10;
	localparam logic [4:0] S_DX = 5'd11;
	localparam logic [4:0] S_MY = 5'd12;
	localparam logic [4:0] S_DY = 5'd13;
	localparam logic [4:0] S_CUTOUT = 5'd14;
	localparam logic [4:0] S_FIN = 5'd15;
	localparam logic [4:0] S_VERT = 5'd16;

	logic [4:0] state_q;

	// configuration
	logic dist_mode_q, num_caps_q;
	logic [1:0] len_caps_q;
	logic [15:0] cut_count_q;
	logic [LB-1:0] cut_length_q;

	// line state
	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [1:0] vip_q;
	logic [LB-1:0] overhang_q, active_q, target_q, cap_q;
	logic caps_differ_q, fcd_q;

	// working registers
	logic [COORD_BITS-1:0] x_q, y_q, ox_q, oy_q;
	logic [PW-1:0] sqx_q;
	logic [LB-1:0] len_q, seg_q, d_q;
	logic [CTW-1:0] cuts_q;
	logic ovf_q;

	// output word
	logic out_valid_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	pfc_pkg::kind_t kind_q;
	logic ovfo_q, last_q;

	// serial unit
	pfc_pkg::alu_ctl_t alu_ctl;
	pfc_pkg::alu_sts_t alu_sts;
	logic [COORD_BITS-1:0] alu_a;
	logic [BW-1:0] alu_b;
	logic [PW-1:0] alu_n, alu_prod;
	logic [LB-1:0] alu_d, alu_rem, alu_root;
	logic [BW-1:0] alu_quot;

	// combinational helpers
	logic [COORD_BITS:0] diff_x, diff_y;
	logic neg_x, neg_y;
	logic [COORD_BITS-1:0] mag_x, mag_y, cut_x, cut_y;
	logic [15:0] cnt_eff;
	logic [16:0] cnt_p1;
	logic [LB:0] room_sum, ov_sum;
	logic do_cut;
	logic [LB-1:0] need, seg_after, d_new, ov_sat;
	logic [SUMW-1:0] sum_sq;
	logic sq_big;
	logic out_free, in_acc, part_path;

	assign diff_x = {x_q[COORD_BITS-1], x_q} - {prev_x_q[COORD_BITS-1], prev_x_q};
	assign diff_y = {y_q[COORD_BITS-1], y_q} - {prev_y_q[COORD_BITS-1], prev_y_q};
	assign neg_x = diff_x[COORD_BITS];
	assign neg_y = diff_y[COORD_BITS];
	assign mag_x = neg_x ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
	assign mag_y = neg_y ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
	assign cut_x = neg_x ? prev_x_q - ox_q : prev_x_q + ox_q;
	assign cut_y = neg_y ? prev_y_q - oy_q : prev_y_q + oy_q;

	assign cnt_eff = (cut_count_q == 16'd0) ? 16'd1 : cut_count_q;
	assign cnt_p1 = {1'b0, cnt_eff} + 17'd1;

	assign room_sum = {1'b0, seg_q} + {1'b0, overhang_q};
	assign do_cut = room_sum > {1'b0, active_q};
	assign need = (overhang_q <= active_q) ? active_q - overhang_q : '0;
	assign seg_after = seg_q - need;
	assign d_new = len_q - seg_after;
	assign ov_sum = {1'b0, overhang_q} + {1'b0, seg_q};
	assign ov_sat = ov_sum[LB] ? pfc_pkg::LEN_MAX : ov_sum[LB-1:0];

	assign sum_sq = SUMW'(sqx_q) + SUMW'(alu_prod);
	assign sq_big = |sum_sq[SUMW-1:pfc_pkg::RAD_BITS];

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign part_path = part_start || (vip_q == 2'd0);
	assign cfg_ready = 1'b1;

	always_comb begin
		alu_ctl.start = 1'b0;
		alu_ctl.op = pfc_pkg::OP_MUL;
		alu_a = mag_x;
		alu_b = BW'(mag_x);
		alu_n = alu_prod;
		alu_d = len_q;
		case (state_q)
			S_IDLE: begin
				alu_ctl.op = pfc_pkg::OP_DIV;
				alu_n = PW'(part_length);
				if (!dist_mode_q) begin
					alu_d = cut_length_q;
					alu_ctl.start = in_acc && part_path && (len_caps_q == 2'd2) &&
						(cut_length_q != '0);
				end else begin
					alu_d = num_caps_q ? LB'(cnt_eff) : LB'(cnt_p1);
					alu_ctl.start = in_acc && part_path;
				end
			end
			S_PREP: alu_ctl.start = (vip_q != 2'd1);
			S_START: alu_ctl.start = out_free;
			S_SQX: begin
				alu_a = mag_y;
				alu_b = BW'(mag_y);
				alu_ctl.start = alu_sts.done;
			end
			S_SQY: begin
				alu_ctl.op = pfc_pkg::OP_SQRT;
				alu_ctl.start = alu_sts.done && !sq_big;
			end
			S_LOOP: begin
				if (cuts_q == CTW'(MAX_CUTS)) begin
					alu_ctl.op = pfc_pkg::OP_DIV;
					alu_n = PW'(seg_q - 1'b1);
					alu_d = active_q;
					alu_ctl.start = do_cut && (active_q != '0);
				end else begin
					alu_b = BW'(d_new);
					alu_ctl.start = do_cut && (len_q != '0);
				end
			end
			S_MX: begin
				alu_ctl.op = pfc_pkg::OP_DIV;
				alu_ctl.start = alu_sts.done;
			end
			S_DX: begin
				alu_a = mag_y;
				alu_b = BW'(d_q);
				alu_ctl.start = alu_sts.done;
			end
			S_MY: begin
				alu_ctl.op = pfc_pkg::OP_DIV;
				alu_ctl.start = alu_sts.done;
			end
			default: alu_ctl.start = 1'b0;
		endcase
	end

	pfc_alu #(
		.COORD_BITS(COORD_BITS)
	) u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(alu_ctl),
		.opa(alu_a),
		.opb(alu_b),
		.opn(alu_n),
		.opd(alu_d),
		.rad(sum_sq[pfc_pkg::RAD_BITS-1:0]),
		.sts(alu_sts),
		.prod(alu_prod),
		.quot(alu_quot),
		.rem(alu_rem),
		.root(alu_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dist_mode_q <= 1'b0;
			len_caps_q <= 2'd0;
			num_caps_q <= 1'b0;
			cut_count_q <= 16'd5;
			cut_length_q <= LB'(327680);
			prev_x_q <= '0;
			prev_y_q <= '0;
			vip_q <= 2'd0;
			overhang_q <= '0;
			active_q <= LB'(327680);
			target_q <= LB'(327680);
			cap_q <= '0;
			caps_differ_q <= 1'b0;
			fcd_q <= 1'b0;
			cuts_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					pfc_pkg::REG_DIST_MODE: dist_mode_q <= cfg_data[0];
					pfc_pkg::REG_LENGTH_CAPS: len_caps_q <= cfg_data[1:0];
					pfc_pkg::REG_NUMBER_CAPS: num_caps_q <= cfg_data[0];
					pfc_pkg::REG_CUT_COUNT: cut_count_q <= cfg_data[15:0];
					pfc_pkg::REG_CUT_LENGTH: begin
						cut_length_q <= cfg_data;
						active_q <= cfg_data;
						target_q <= cfg_data;
					end
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						ovf_q <= 1'b0;
						if (part_path) begin
							prev_x_q <= vertex_x;
							prev_y_q <= vertex_y;
							vip_q <= 2'd1;
							fcd_q <= 1'b0;
							if (!dist_mode_q) begin
								if (len_caps_q == 2'd0)
									overhang_q <= '0;
								if (len_caps_q == 2'd2) begin
									caps_differ_q <= 1'b1;
									overhang_q <= '0;
									target_q <= cut_length_q;
									if (cut_length_q != '0)
										state_q <= S_PART;
									else
										cap_q <= '0;
								end
							end else begin
								overhang_q <= '0;
								if (num_caps_q)
									caps_differ_q <= 1'b1;
								state_q <= S_PART;
							end
						end else begin
							state_q <= (vip_q == 2'd1) ? S_START : S_PREP;
						end
					end
				end
				S_PART: begin
					if (alu_sts.done) begin
						if (!dist_mode_q) begin
							cap_q <= alu_rem >> 1;
						end else if (!num_caps_q) begin
							active_q <= alu_quot[LB-1:0];
						end else begin
							target_q <= alu_quot[LB-1:0];
							cap_q <= LB'(alu_quot[LB-1:1]);
							active_q <= alu_quot[LB-1:0];
						end
						state_q <= S_IDLE;
					end
				end
				S_PREP: state_q <= S_SQX;
				S_START: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						vip_q <= 2'd2;
						state_q <= S_SQX;
					end
				end
				S_SQX: begin
					if (alu_sts.done) begin
						sqx_q <= alu_prod;
						state_q <= S_SQY;
					end
				end
				S_SQY: begin
					if (alu_sts.done) begin
						if (sq_big) begin
							len_q <= pfc_pkg::LEN_MAX;
							state_q <= S_SEG;
						end else begin
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (alu_sts.done) begin
						len_q <= alu_root;
						state_q <= S_SEG;
					end
				end
				S_SEG: begin
					seg_q <= len_q;
					cuts_q <= '0;
					if (!fcd_q && caps_differ_q)
						active_q <= cap_q;
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (!do_cut) begin
						state_q <= S_FIN;
					end else if (cuts_q == CTW'(MAX_CUTS)) begin
						ovf_q <= 1'b1;
						if (active_q != '0) begin
							state_q <= S_OVF;
						end else begin
							seg_q <= '0;
							state_q <= S_FIN;
						end
					end else begin
						seg_q <= seg_after;
						overhang_q <= '0;
						d_q <= d_new;
						if (len_q != '0) begin
							state_q <= S_MX;
						end else begin
							ox_q <= '0;
							oy_q <= '0;
							state_q <= S_CUTOUT;
						end
					end
				end
				S_OVF: begin
					if (alu_sts.done) begin
						seg_q <= alu_rem + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_MX: if (alu_sts.done) state_q <= S_DX;
				S_DX: begin
					if (alu_sts.done) begin
						ox_q <= alu_quot[COORD_BITS-1:0];
						state_q <= S_MY;
					end
				end
				S_MY: if (alu_sts.done) state_q <= S_DY;
				S_DY: begin
					if (alu_sts.done) begin
						oy_q <= alu_quot[COORD_BITS-1:0];
						state_q <= S_CUTOUT;
					end
				end
				S_CUTOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (!fcd_q && caps_differ_q)
							active_q <= target_q;
						fcd_q <= 1'b1;
						cuts_q <= cuts_q + 1'b1;
						state_q <= S_LOOP;
					end
				end
				S_FIN: begin
					overhang_q <= ov_sat;
					state_q <= S_VERT;
				end
				S_VERT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						prev_x_q <= x_q;
						prev_y_q <= y_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// input latch and output word payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= vertex_x;
			y_q <= vertex_y;
		end
		if (out_free) begin
			case (state_q)
				S_START: begin
					px_q <= prev_x_q;
					py_q <= prev_y_q;
					kind_q <= pfc_pkg::KIND_START;
					ovfo_q <= 1'b0;
					last_q <= 1'b0;
				end
				S_CUTOUT: begin
					px_q <= cut_x;
					py_q <= cut_y;
					kind_q <= pfc_pkg::KIND_CUT;
					ovfo_q <= 1'b0;
					last_q <= 1'b0;
				end
				S_VERT: begin
					px_q <= x_q;
					py_q <= y_q;
					kind_q <= pfc_pkg::KIND_VERTEX;
					ovfo_q <= ovf_q;
					last_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign point_kind = kind_q;
	assign overflow = ovfo_q;
	assign last = last_q;

`include "polyline_fixed_length_cutter_top_assert.svh"

	`PFC_ASSERT_IMP(a_alu_start_free, alu_ctl.start, !alu_sts.busy, "serial unit restarted while busy")
	`PFC_ASSERT_IMP(a_cuts_bound, 1'b1, cuts_q <= CTW'(MAX_CUTS), "cut counter past limit")
	`PFC_ASSERT_NXT(a_vertex_holds, in_acc && !part_path, !in_ready, "ready during vertex work")
	`PFC_ASSERT_IMP(a_ovf_on_vertex, out_valid_q && ovfo_q, (kind_q == pfc_pkg::KIND_VERTEX) && last_q, "overflow off vertex word")

endmodule
